/* hw/rtl/sel_pkg.sv */
// sel_pkg: shared types and constants of the scan-line edge locator
// used by sel_ctrl, sel_datapath and scanline_edge_locator
package sel_pkg;

    localparam int MAX_LINE    = 2048;
    localparam int SAMPLE_BITS = 12;
    localparam int CNT_W       = $clog2(MAX_LINE);
    localparam int ENV_W       = 30;
    localparam int SPAN_W      = 29;
    localparam int PROD_W      = 44;

    localparam logic [1:0] REG_LOWER_START = 2'd0;
    localparam logic [1:0] REG_START_RATE  = 2'd1;
    localparam logic [1:0] REG_RATE_SHIFT  = 2'd2;
    localparam logic [1:0] REG_GAIN        = 2'd3;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENV,
        ST_MUL,
        ST_JUDGE,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic env;
        logic mul;
        logic judge;
        logic div_start;
        logic div_step;
        logic push_edge;
        logic push_line;
    } cmd_t;

    typedef struct packed {
        logic crossing;
        logic hit;
        logic div_done;
        logic eol;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic        kind;
        logic [11:0] slot;
        logic [10:0] whole;
        logic [7:0]  frac;
        logic [12:0] slope;
        logic [11:0] total;
    } result_t;

endpackage

/* hw/rtl/scanline_edge_locator.sv */
// scanline_edge_locator: top level, configuration registers and stream ports
// depends on sel_pkg, sel_ctrl, sel_datapath
// One sample is taken at a time; the sample is held until the sequencer
// returns to idle, through the steps for the envelope, products, judgement
// and, for an edge, the bit-serial fraction divider (one quotient bit a
// cycle). Results wait in one output register; a line end after an edge
// is pushed once that register is free, so it waits on the result side.
module scanline_edge_locator import sel_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample[11:0]
    input  logic        s_tlast,   // end_of_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // edge_slot, position_whole, position_fraction,
                                   // edge_slope, edge_total
    output logic        m_tuser,   // event_kind
    output logic        m_tlast    // last_of_run
);

    logic [11:0] lower_start_reg, start_rate_reg;
    logic [3:0]  rate_shift_reg;
    logic [7:0]  gain_reg;
    logic        busy, in_fire;
    cmd_t        cmd;
    stat_t       stat;
    result_t     item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_start_reg <= 12'd3000;
            start_rate_reg  <= 12'd32;
            rate_shift_reg  <= 4'd6;
            gain_reg        <= 8'd16;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LOWER_START: lower_start_reg <= cfg_data;
                REG_START_RATE:  start_rate_reg  <= cfg_data;
                REG_RATE_SHIFT:  rate_shift_reg  <= cfg_data[3:0];
                REG_GAIN:        gain_reg        <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;

    sel_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .stat(stat),
        .busy(busy), .cmd(cmd)
    );

    sel_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_sample(s_tdata[SAMPLE_BITS-1:0]), .in_eol(s_tlast),
        .cfg_lower_start(lower_start_reg), .cfg_start_rate(start_rate_reg),
        .cfg_rate_shift(rate_shift_reg), .cfg_gain(gain_reg),
        .out_ready(m_tready), .out_valid(m_tvalid), .out_item(item), .out_last(m_tlast)
    );

    assign m_tdata = {item.total, item.slope, item.frac, item.whole, item.slot};
    assign m_tuser = item.kind;

endmodule

/* hw/rtl/sel_ctrl.sv */
// sel_ctrl: sequencer for one sample: envelope, products, judgement, fraction
// depends on sel_pkg
module sel_ctrl import sel_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_fire,
    input  stat_t stat,
    output logic  busy,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_ENV;
            ST_ENV:   state_next = stat.crossing ? ST_MUL : ST_EMIT;
            ST_MUL:   state_next = ST_JUDGE;
            ST_JUDGE: state_next = stat.hit ? ST_DIV : ST_EMIT;
            ST_DIV:   if (stat.div_done && stat.out_free) state_next = stat.eol ? ST_EMIT : ST_IDLE;
            ST_EMIT:  if (!stat.eol || stat.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:  cmd.load = in_fire;
            ST_ENV:   cmd.env = 1'b1;
            ST_MUL:   cmd.mul = 1'b1;
            ST_JUDGE: begin
                cmd.judge = 1'b1;
                cmd.div_start = stat.hit;
            end
            ST_DIV: begin
                cmd.div_step = !stat.div_done;
                cmd.push_edge = stat.div_done && stat.out_free;
            end
            ST_EMIT:  cmd.push_line = stat.eol && stat.out_free;
            default:  cmd = '0;
        endcase
    end

    a_push_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.push_edge && cmd.push_line)) else $error("two pushes at once");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_ENV) else $error("load did not start");
    a_div_after_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> $past(state_reg) == ST_DIV || $past(state_reg) == ST_JUDGE)
        else $error("divide entered wrongly");

endmodule

/* hw/rtl/sel_datapath.sv */
// sel_datapath: envelope, curvature, hysteresis and fraction divider
// depends on sel_pkg; driven by sel_ctrl commands
module sel_datapath import sel_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cmd_t                   cmd,
    output stat_t                  stat,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic                   in_eol,
    input  logic [11:0]            cfg_lower_start,
    input  logic [11:0]            cfg_start_rate,
    input  logic [3:0]             cfg_rate_shift,
    input  logic [7:0]             cfg_gain,
    input  logic                   out_ready,
    output logic                   out_valid,
    output result_t                out_item,
    output logic                   out_last
);

    logic [CNT_W-1:0]       cnt_reg;
    logic [SAMPLE_BITS-1:0] y_reg, h0_reg, h1_reg;
    logic                   eol_reg;
    logic signed [ENV_W-1:0] up_reg, lo_reg, step_reg;
    logic signed [ENV_W-1:0] du0_reg, dl0_reg, du1_reg, dl1_reg;
    logic                   rising_reg;
    logic signed [13:0]     rext_reg, fext_reg;
    logic [11:0]            slot_reg;
    logic signed [13:0]     pcurv_reg, curv_reg, pcu_reg, fx_reg;
    logic signed [SPAN_W-1:0] span_reg;
    logic [ENV_W:0]         amag_reg;
    logic signed [PROD_W-1:0] pr_reg, pf_reg, ga_reg;
    logic [12:0]            slope_reg;
    logic [CNT_W-1:0]       whole_reg;
    logic [13:0]            au_reg, den_reg;
    logic [21:0]            rem_reg;
    logic [7:0]             q_reg;
    logic [3:0]             dcnt_reg;
    logic                   ov_reg, ol_reg;
    result_t                oi_reg;

    logic signed [ENV_W-1:0] w, up0, lo0, st0, cu, cl, nu, nl;
    logic signed [SPAN_W-1:0] span;
    logic signed [13:0]      curv, fx;
    logic signed [ENV_W:0]   asum;
    logic [ENV_W:0]          amag;
    logic [13:0]             aabs, dabs;
    logic                    new_line;
    logic                    crossing;
    logic                    r_up, r_dn, f_up, f_dn, hit;
    logic [22:0]             trial;

    assign new_line = (cnt_reg == '0);
    assign w   = ENV_W'(signed'({1'b0, y_reg})) <<< 16;
    assign up0 = new_line ? '0 : up_reg;
    assign lo0 = new_line ? (ENV_W'(signed'({1'b0, cfg_lower_start})) <<< 16) : lo_reg;
    assign st0 = new_line ? (ENV_W'(signed'({1'b0, cfg_start_rate})) <<< 10) : step_reg;
    assign cu  = up0 - st0;
    assign cl  = lo0 + st0;
    assign nu  = (w >= cu) ? w : cu;
    assign nl  = (w <= cl) ? w : cl;
    assign curv = 14'(signed'({2'b0, y_reg})) - (14'(signed'({2'b0, h0_reg})) <<< 1)
                + 14'(signed'({2'b0, h1_reg}));
    assign span = SPAN_W'(du1_reg - dl1_reg);
    assign fx   = 14'(signed'({2'b0, h0_reg})) - 14'(signed'({2'b0, h1_reg}));
    assign asum = (ENV_W+1)'(du1_reg) + (ENV_W+1)'(dl1_reg)
                - ((ENV_W+1)'(signed'({1'b0, h1_reg})) <<< 17);
    assign amag = asum[ENV_W] ? (ENV_W+1)'(-asum) : (ENV_W+1)'(asum);
    assign crossing = (cnt_reg >= CNT_W'(3)) && (span > 0)
        && ((pcurv_reg >= 0 && curv < 0) || (pcurv_reg <= 0 && curv > 0));
    assign r_up = pr_reg > ga_reg;
    assign r_dn = pr_reg < -ga_reg;
    assign f_up = pf_reg > ga_reg;
    assign f_dn = pf_reg < -ga_reg;
    assign hit  = rising_reg ? (r_up || r_dn) : (f_up || f_dn);
    assign aabs = pcu_reg[13] ? 14'(-pcu_reg) : 14'(pcu_reg);
    assign dabs = curv_reg[13] ? 14'(-curv_reg) : 14'(curv_reg);
    assign trial = {rem_reg, 1'b0} - {9'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0; h0_reg <= '0; h1_reg <= '0;
            up_reg <= '0; lo_reg <= ENV_W'(3000) <<< 16; step_reg <= ENV_W'(32) <<< 10;
            du0_reg <= '0; dl0_reg <= '0; du1_reg <= '0; dl1_reg <= '0;
            rising_reg <= 1'b0; rext_reg <= '0; fext_reg <= '0;
            slot_reg <= '0; pcurv_reg <= '0;
            dcnt_reg <= '0; eol_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                y_reg <= in_sample;
                eol_reg <= in_eol;
            end
            if (cmd.env) begin
                if (new_line) begin
                    rising_reg <= 1'b0; rext_reg <= '0; fext_reg <= '0; slot_reg <= 12'd2;
                end
                up_reg <= nu;
                lo_reg <= nl;
                step_reg <= (nu - nl) >>> cfg_rate_shift;
                if (cnt_reg == CNT_W'(1)) begin
                    rising_reg <= y_reg > h0_reg;
                    slot_reg <= (y_reg > h0_reg) ? 12'd1 : 12'd2;
                    rext_reg <= '0; fext_reg <= '0;
                end
                curv_reg <= curv;
                pcu_reg <= pcurv_reg;
                if (cnt_reg >= CNT_W'(2)) pcurv_reg <= curv;
                fx_reg <= fx;
                span_reg <= span;
                amag_reg <= amag;
                slope_reg <= 13'(fx);
                whole_reg <= cnt_reg - CNT_W'(2);
                du1_reg <= du0_reg; dl1_reg <= dl0_reg;
                du0_reg <= nu; dl0_reg <= nl;
                h1_reg <= h0_reg; h0_reg <= y_reg;
                if (eol_reg) cnt_reg <= '0;
                else if (cnt_reg != CNT_W'(MAX_LINE-1)) cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.mul) begin
                pr_reg <= PROD_W'(fx_reg - rext_reg) * PROD_W'(span_reg);
                pf_reg <= PROD_W'(fx_reg - fext_reg) * PROD_W'(span_reg);
                ga_reg <= PROD_W'(signed'({1'b0, cfg_gain})) * PROD_W'(signed'(amag_reg));
            end
            if (cmd.judge) begin
                if (rising_reg) begin
                    if (r_up) rext_reg <= fx_reg;
                    if (r_dn && !r_up) begin
                        rising_reg <= 1'b0; fext_reg <= fx_reg; slot_reg <= slot_reg + 12'd1;
                    end
                end else begin
                    if (f_up) begin
                        rising_reg <= 1'b1; rext_reg <= fx_reg; slot_reg <= slot_reg + 12'd1;
                    end
                    if (f_dn && !f_up) fext_reg <= fx_reg;
                end
            end
            if (cmd.div_start) begin
                au_reg <= aabs;
                den_reg <= aabs + dabs;
                rem_reg <= {8'b0, aabs};
                q_reg <= '0;
                dcnt_reg <= 4'd9;
            end
            if (cmd.div_step) begin
                if (dcnt_reg == 4'd9) begin
                    rem_reg <= 22'(au_reg) << 0;
                    dcnt_reg <= 4'd8;
                    q_reg <= '0;
                end else begin
                    if (!trial[22]) begin
                        rem_reg <= trial[21:0]; q_reg <= {q_reg[6:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[20:0], 1'b0}; q_reg <= {q_reg[6:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg - 4'd1;
                end
            end
        end
    end

    // fraction: first step reloads the remainder, then one quotient bit per step over 8 steps
    assign stat.crossing = crossing;
    assign stat.hit      = hit;
    assign stat.div_done = (dcnt_reg == 4'd0);
    assign stat.eol      = eol_reg;
    assign stat.out_free = !ov_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else begin
            if (cmd.push_edge || cmd.push_line) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
        end
        if (cmd.push_edge) begin
            oi_reg <= '{kind: KIND_EDGE, slot: slot_reg, whole: 11'(whole_reg),
                        frac: q_reg, slope: slope_reg, total: 12'd0};
            ol_reg <= !eol_reg;
        end else if (cmd.push_line) begin
            oi_reg <= '{kind: KIND_LINE, slot: 12'd0, whole: 11'd0, frac: 8'd0,
                        slope: 13'd0, total: slot_reg};
            ol_reg <= 1'b1;
        end
    end

    assign out_valid = ov_reg;
    assign out_item  = oi_reg;
    assign out_last  = ol_reg;

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push_edge || cmd.push_line) |-> (!ov_reg || out_ready))
        else $error("result overwritten");
    a_div_one: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> dcnt_reg == 4'd9) else $error("divider not armed");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && !out_ready && !cmd.push_edge && !cmd.push_line) |=> ov_reg)
        else $error("result dropped");

endmodule

/* tb/sv/scanline_edge_checker.sv */
// scanline_edge_checker: watches the sample and result streams of scanline_edge_locator
// keeps its own copy of the edge finder state and compares every result transfer
// depends on sel_pkg
`timescale 1ns / 1ps
module scanline_edge_checker import sel_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          mismatches,
    output int          pending
);

    typedef struct {
        logic        kind;
        logic [11:0] slot;
        logic [10:0] whole;
        logic [7:0]  frac;
        logic [12:0] slope;
        logic [11:0] total;
        logic        last;
    } edge_event_t;

    edge_event_t expected_events[$];

    logic [11:0] lower_start_q, start_rate_q, gain_q;
    logic [3:0]  rate_shift_q;

    int unsigned sample_idx;
    longint      hist [3];
    longint      env_up, env_lo, decay;
    longint      dly_up [2];
    longint      dly_lo [2];
    logic        rising;
    longint      rise_x, fall_x, prior_curv;
    logic [11:0] slot_cnt;

    assign pending = expected_events.size();

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic push_event(logic kind, logic [11:0] slot, logic [10:0] whole,
                              logic [7:0] frac, logic [12:0] slope, logic [11:0] total);
        edge_event_t ev;
        ev.kind = kind; ev.slot = slot; ev.whole = whole; ev.frac = frac;
        ev.slope = slope; ev.total = total; ev.last = 1'b0;
        expected_events.push_back(ev);
    endtask

    task automatic locate_edges(logic [11:0] y_in, logic eol);
        longint      y, w, nu, nl, curv, s, fx, a, ga, au, ad;
        int unsigned n;
        int          made;
        logic        hit;
        y = y_in;
        w = y <<< 16;
        n = sample_idx;
        made = 0;
        if (n == 0) begin
            env_up = 0;
            env_lo = longint'(lower_start_q) <<< 16;
            decay = longint'(start_rate_q) <<< 10;
            rising = 1'b0;
            rise_x = 0;
            fall_x = 0;
            slot_cnt = 12'd2;
        end
        nu = (w >= env_up - decay) ? w : env_up - decay;
        nl = (w <= env_lo + decay) ? w : env_lo + decay;
        env_up = nu;
        env_lo = nl;
        decay = (nu - nl) >>> rate_shift_q;
        if (n == 1) begin
            rising = (y - hist[0]) > 0;
            slot_cnt = rising ? 12'd1 : 12'd2;
            rise_x = 0;
            fall_x = 0;
        end
        if (n >= 2) begin
            curv = y - 2 * hist[0] + hist[1];
            if (n >= 3) begin
                s = dly_up[1] - dly_lo[1];
                if (((prior_curv >= 0 && curv < 0) || (prior_curv <= 0 && curv > 0))
                        && s > 0) begin
                    fx = hist[0] - hist[1];
                    a = magnitude(dly_up[1] + dly_lo[1] - 2 * (hist[1] <<< 16));
                    ga = longint'(gain_q[7:0]) * a;
                    hit = 1'b0;
                    if (rising) begin
                        if ((fx - rise_x) * s > ga) begin
                            rise_x = fx;
                            hit = 1'b1;
                        end
                        if ((fx - rise_x) * s < -ga) begin
                            rising = 1'b0;
                            fall_x = fx;
                            slot_cnt = slot_cnt + 12'd1;
                            hit = 1'b1;
                        end
                    end else begin
                        if ((fx - fall_x) * s > ga) begin
                            rise_x = fx;
                            rising = 1'b1;
                            slot_cnt = slot_cnt + 12'd1;
                            hit = 1'b1;
                        end
                        if ((fx - fall_x) * s < -ga) begin
                            fall_x = fx;
                            hit = 1'b1;
                        end
                    end
                    if (hit) begin
                        au = magnitude(prior_curv);
                        ad = magnitude(curv);
                        push_event(KIND_EDGE, slot_cnt, 11'(n - 2), 8'((au * 256) / (au + ad)),
                                   13'(fx), 12'd0);
                        made++;
                    end
                end
            end
            prior_curv = curv;
        end
        dly_up[1] = dly_up[0];
        dly_lo[1] = dly_lo[0];
        dly_up[0] = nu;
        dly_lo[0] = nl;
        hist[2] = hist[1];
        hist[1] = hist[0];
        hist[0] = y;
        if (n < MAX_LINE - 1) sample_idx = n + 1;
        if (eol) begin
            push_event(KIND_LINE, 12'd0, 11'd0, 8'd0, 13'd0, slot_cnt);
            made++;
            sample_idx = 0;
        end
        if (made > 0) expected_events[$].last = 1'b1;
    endtask

    always @(posedge aclk) begin
        edge_event_t ev;
        if (!aresetn) begin
            lower_start_q = 12'd3000;
            start_rate_q = 12'd32;
            rate_shift_q = 4'd6;
            gain_q = 12'd16;
            sample_idx = 0;
            hist = '{0, 0, 0};
            env_up = 0;
            env_lo = longint'(lower_start_q) <<< 16;
            decay = longint'(start_rate_q) <<< 10;
            dly_up = '{0, 0};
            dly_lo = '{0, 0};
            rising = 1'b0;
            rise_x = 0;
            fall_x = 0;
            slot_cnt = 12'd0;
            prior_curv = 0;
            expected_events.delete();
            mismatches = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_LOWER_START: lower_start_q = cfg_data;
                    REG_START_RATE:  start_rate_q = cfg_data;
                    REG_RATE_SHIFT:  rate_shift_q = cfg_data[3:0];
                    REG_GAIN:        gain_q = {4'd0, cfg_data[7:0]};
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, actual kind %0d data %h",
                             $time, m_tuser, m_tdata);
                    mismatches++;
                end else begin
                    ev = expected_events.pop_front();
                    if (m_tuser !== ev.kind || m_tdata[11:0] !== ev.slot
                            || m_tdata[22:12] !== ev.whole || m_tdata[30:23] !== ev.frac
                            || m_tdata[43:31] !== ev.slope || m_tdata[55:44] !== ev.total
                            || m_tlast !== ev.last) begin
                        $display("%0t: expected kind %0d slot %0d whole %0d frac %0d slope %0d total %0d last %0d",
                                 $time, ev.kind, ev.slot, ev.whole, ev.frac,
                                 $signed(ev.slope), ev.total, ev.last);
                        $display("%0t: actual   kind %0d slot %0d whole %0d frac %0d slope %0d total %0d last %0d",
                                 $time, m_tuser, m_tdata[11:0], m_tdata[22:12], m_tdata[30:23],
                                 $signed(m_tdata[43:31]), m_tdata[55:44], m_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) locate_edges(s_tdata[11:0], s_tlast);
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// tb_top: stimulus and verdict for scanline_edge_locator
// depends on sel_pkg, scanline_edge_locator and scanline_edge_checker
`timescale 1ns / 1ps
module tb_top;
    import sel_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_LOWER_START;
    logic [11:0] cfg_data = 12'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    int          mismatches;
    int          pending;
    bit          quiet = 1'b0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    int          sent = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    scanline_edge_locator dut (.*);
    scanline_edge_checker checker_i (.*);

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 4000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_sample(logic [11:0] y, logic eol);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'd0, y};
        s_tlast <= eol;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic drain_and_configure(logic [11:0] lo_start, logic [11:0] rate,
                                       logic [3:0] shift, logic [7:0] gain);
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= REG_LOWER_START; cfg_data <= lo_start; @(posedge aclk);
        cfg_index <= REG_START_RATE;  cfg_data <= rate;     @(posedge aclk);
        cfg_index <= REG_RATE_SHIFT;  cfg_data <= {8'd0, shift}; @(posedge aclk);
        cfg_index <= REG_GAIN;        cfg_data <= {4'd0, gain};  @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_line(int len, int jump_odds, int noise);
        int level;
        int y;
        level = $urandom_range(0, 4095);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, jump_odds) == 0) level = $urandom_range(0, 4095);
            y = level + $urandom_range(0, 2 * noise) - noise;
            if ($urandom_range(0, 30) == 0) y = $urandom_range(0, 1) ? 4095 : 0;
            y = (y < 0) ? 0 : (y > 4095) ? 4095 : y;
            send_sample(12'(y), k == len - 1);
        end
    endtask

    initial begin
        int len;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // short lines, extremes and a sharp step
        send_sample(12'd100, 1'b1);
        send_sample(12'd0, 1'b0);    send_sample(12'd4095, 1'b1);
        send_sample(12'd4095, 1'b0); send_sample(12'd0, 1'b0); send_sample(12'd7, 1'b1);
        send_sample(12'd0, 1'b0);    send_sample(12'd0, 1'b0);
        send_sample(12'd4095, 1'b0); send_sample(12'd4095, 1'b1);
        send_sample(12'd50, 1'b0);   send_sample(12'd40, 1'b0);  send_sample(12'd4000, 1'b0);
        send_sample(12'd4095, 1'b0); send_sample(12'd10, 1'b0);  send_sample(12'd0, 1'b1);

        // flat line at zero gives zero span
        drain_and_configure(12'd0, 12'd0, 4'd0, 8'd0);
        for (int k = 0; k < 8; k++) send_sample(12'd0, k == 7);
        send_line(12, 2, 30);

        drain_and_configure(12'd4095, 12'd4095, 4'd15, 8'd255);
        send_line(20, 3, 100);

        drain_and_configure(12'd3000, 12'd32, 4'd6, 8'd16);
        while (sent < 500) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 60);
            send_line(len, $urandom_range(2, 12), $urandom_range(0, 200));
        end

        drain_and_configure(12'($urandom), 12'($urandom), 4'($urandom), 8'($urandom_range(0, 8)));
        // long line
        send_line(200, 20, 40);
        while (sent < 1100) begin
            len = $urandom_range(1, 50);
            send_line(len, $urandom_range(1, 10), $urandom_range(0, 400));
        end

        drain_and_configure(12'($urandom), 12'($urandom), 4'($urandom_range(0, 4)), 8'($urandom));
        quiet = 1'b1;
        while (sent < 1350) send_line($urandom_range(4, 40), $urandom_range(2, 8), 150);

        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
